>>> src/btdc_pkg.sv
// Shared types, displacement-kind codes and the opcode table for the
// branch target displacement codec. No dependencies.
`timescale 1ns / 1ps

package btdc_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_NONE     = 3'd0;
    localparam kind_t KIND_INDIRECT = 3'd1;
    localparam kind_t KIND_D4       = 3'd2;
    localparam kind_t KIND_D4LOOP   = 3'd3;
    localparam kind_t KIND_D8       = 3'd4;
    localparam kind_t KIND_D15      = 3'd5;
    localparam kind_t KIND_D24      = 3'd6;
    localparam kind_t KIND_UNKNOWN  = 3'd7;

    typedef struct packed {
        logic        mode;
        logic [31:0] instr_word;
        logic        is_short;
        logic [31:0] pc_addr;
        logic [31:0] new_target;
    } req_t;

    typedef struct packed {
        logic [31:0] branch_target;
        logic        target_valid;
        logic [2:0]  disp_kind;
        logic [31:0] patched_word;
        logic        unknown_opcode;
    } rsp_t;

    // Sort an opcode byte into its displacement kind.
    function automatic kind_t classify(input logic [7:0] op);
        kind_t k;
        unique case (op)
            8'h6D, 8'h1D:
                k = KIND_D24;
            8'hDF, 8'h5F, 8'h7D, 8'hFF, 8'h7F, 8'hBF, 8'h3F, 8'h9F, 8'h1F,
            8'hBD, 8'h6F, 8'hFD, 8'hEF:
                k = KIND_D15;
            8'h5C, 8'h3C, 8'hEE, 8'h6E:
                k = KIND_D8;
            8'h1E, 8'h3E, 8'hCE, 8'h4E, 8'h8E, 8'h0E, 8'h5E, 8'h7E, 8'hAE,
            8'hF6, 8'h7C, 8'h76, 8'hBC, 8'h2E:
                k = KIND_D4;
            8'hFC:
                k = KIND_D4LOOP;
            8'h00:
                k = KIND_NONE;
            8'h2D, 8'hDC:
                k = KIND_INDIRECT;
            default:
                k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

>>> src/btdc_if.sv
// Valid/ready channel interfaces for the request and result items.
// Depends on nothing; field widths follow the codec's item layout.
`timescale 1ns / 1ps

interface btdc_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] instr_word;
    logic        is_short;
    logic [31:0] pc_addr;
    logic [31:0] new_target;

    modport source (output valid, mode, instr_word, is_short, pc_addr, new_target,
                    input ready);
    modport sink   (input valid, mode, instr_word, is_short, pc_addr, new_target,
                    output ready);
endinterface

interface btdc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] branch_target;
    logic        target_valid;
    logic [2:0]  disp_kind;
    logic [31:0] patched_word;
    logic        unknown_opcode;

    modport source (output valid, branch_target, target_valid, disp_kind, patched_word,
                    unknown_opcode, input ready);
    modport sink   (input valid, branch_target, target_valid, disp_kind, patched_word,
                    unknown_opcode, output ready);
endinterface

>>> src/branch_target_displacement_codec_unit.sv
// Branch target displacement codec: top level with input and result registers.
// Depends on btdc_pkg, btdc_if.sv and btdc_decode.
`timescale 1ns / 1ps
//
// Usage
//   req: one instruction word with its address, mode and wanted target per item.
//   rsp: one result item per request item, in order: target address and valid
//        flag, displacement kind, rewritten word and unknown-opcode flag.
//   An item is taken on req when valid and ready are both high at a clock edge.
// Pipeline: an accepted item passes through two register stages, the input
//   register and then the result register, before it is presented on rsp.
// Throughput: one item per cycle while rsp.ready stays high; the decode and
//   the 32-bit add sit in one stage between the two registers.
// Reset (rst_n low, asynchronous): both stages empty, rsp.valid low, no
//   results pending; the payload registers are not reset.
// Stall: while rsp.ready is low the result holds; the input stage still takes
//   an item if it is empty, after which req.ready drops until the result
//   register drains. Nothing is lost or repeated.
//
module branch_target_displacement_codec_unit
(
    input  logic           clk,
    input  logic           rst_n,
    btdc_req_if.sink       req,
    btdc_rsp_if.source     rsp
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    btdc_pkg::req_t  s1_data_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    btdc_pkg::rsp_t  out_data_reg;
    btdc_pkg::rsp_t  dec_result;
    logic            out_free;
    logic            s1_free;
    logic            req_take;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_free   = !s1_valid_reg || out_free;
    assign req.ready = s1_free;
    assign req_take  = req.valid && s1_free;

    assign s1_valid_next  = req_take ? 1'b1 : (out_free ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    btdc_decode u_decode
    (
        .req_item (s1_data_reg),
        .rsp_item (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_data_reg.mode       <= req.mode;
            s1_data_reg.instr_word <= req.instr_word;
            s1_data_reg.is_short   <= req.is_short;
            s1_data_reg.pc_addr    <= req.pc_addr;
            s1_data_reg.new_target <= req.new_target;
        end
        if (out_free && s1_valid_reg)
        begin
            out_data_reg <= dec_result;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.branch_target  = out_data_reg.branch_target;
    assign rsp.target_valid   = out_data_reg.target_valid;
    assign rsp.disp_kind      = out_data_reg.disp_kind;
    assign rsp.patched_word   = out_data_reg.patched_word;
    assign rsp.unknown_opcode = out_data_reg.unknown_opcode;

endmodule

>>> src/btdc_decode.sv
// Combinational decode, target add and displacement rewrite for one item.
// Depends on btdc_pkg.
`timescale 1ns / 1ps

module btdc_decode
(
    input  btdc_pkg::req_t req_item,
    output btdc_pkg::rsp_t rsp_item
);

    logic [31:0]    word;
    btdc_pkg::kind_t kind;
    logic           direct;
    logic [31:0]    offset;
    logic [31:0]    new_off;
    logic [31:0]    rewritten;

    // Drop the upper half of a short word before anything else sees it.
    assign word   = req_item.is_short ? {16'h0000, req_item.instr_word[15:0]}
                                      : req_item.instr_word;
    assign kind   = btdc_pkg::classify(word[7:0]);
    assign direct = (kind == btdc_pkg::KIND_D4) || (kind == btdc_pkg::KIND_D4LOOP) ||
                    (kind == btdc_pkg::KIND_D8) || (kind == btdc_pkg::KIND_D15) ||
                    (kind == btdc_pkg::KIND_D24);
    assign new_off = req_item.new_target - req_item.pc_addr;

    always_comb
    begin
        unique case (kind)
            btdc_pkg::KIND_D4:
                offset = {27'd0, word[11:8], 1'b0};
            btdc_pkg::KIND_D4LOOP:
                offset = {{27{1'b1}}, word[11:8], 1'b0};
            btdc_pkg::KIND_D8:
                offset = {{23{word[15]}}, word[15:8], 1'b0};
            btdc_pkg::KIND_D15:
                offset = {{16{word[30]}}, word[30:16], 1'b0};
            btdc_pkg::KIND_D24:
                offset = {{7{word[15]}}, word[15:8], word[31:16], 1'b0};
            default:
                offset = 32'd0;
        endcase
    end

    always_comb
    begin
        unique case (kind)
            btdc_pkg::KIND_D4, btdc_pkg::KIND_D4LOOP:
                rewritten = {word[31:12], new_off[4:1], word[7:0]};
            btdc_pkg::KIND_D8:
                rewritten = {word[31:16], new_off[8:1], word[7:0]};
            btdc_pkg::KIND_D15:
                rewritten = {word[31], new_off[15:1], word[15:0]};
            btdc_pkg::KIND_D24:
                // sign of the whole offset lands in bit 15
                rewritten = {new_off[16:1], new_off[31], new_off[23:17], word[7:0]};
            default:
                rewritten = word;
        endcase
    end

    always_comb
    begin
        rsp_item.branch_target  = direct ? (req_item.pc_addr + offset) : 32'd0;
        rsp_item.target_valid   = direct;
        rsp_item.disp_kind      = (kind == btdc_pkg::KIND_UNKNOWN) ? btdc_pkg::KIND_NONE : kind;
        rsp_item.unknown_opcode = (kind == btdc_pkg::KIND_UNKNOWN);
        if (direct && req_item.mode)
        begin
            rsp_item.patched_word = req_item.is_short ? {16'h0000, rewritten[15:0]}
                                                      : rewritten;
        end
        else
        begin
            rsp_item.patched_word = word;
        end
    end

endmodule
